### rtl/iritt_pkg.sv
package iritt_pkg;

    // Item kinds on the input stream
    typedef enum logic [1:0] {
        ACT_ALLOC    = 2'd0,
        ACT_RESPONSE = 2'd1,
        ACT_RELEASE  = 2'd2
    } action_t;

    // Result outcome codes
    typedef enum logic [3:0] {
        OUT_OK           = 4'd0,
        OUT_NO_FREE_TAG  = 4'd1,
        OUT_BAD_REQ_LEN  = 4'd2,
        OUT_TAG_RANGE    = 4'd3,
        OUT_TAG_NOT_BUSY = 4'd4,
        OUT_BAD_RESP_LEN = 4'd5,
        OUT_UNSUPPORTED  = 4'd6,
        OUT_FAILED       = 4'd7,
        OUT_RELEASED     = 4'd8
    } outcome_t;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_ACTIVE_TAGS   = 3'd0,
        CFG_MAX_REQ_LEN   = 3'd1,
        CFG_HEADER_LEN    = 3'd2,
        CFG_MORE_ENTRIES  = 3'd3,
        CFG_UNSUPPORTED   = 3'd4
    } cfg_index_t;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int IN_TDATA_W  = 88;
    localparam int OUT_TDATA_W = 16;

    // Reset values of the configuration registers
    localparam logic [6:0]  ACTIVE_TAGS_RST  = 7'd64;
    localparam logic [15:0] MAX_REQ_LEN_RST  = 16'd4096;
    localparam logic [7:0]  HEADER_LEN_RST   = 8'd24;
    localparam logic [31:0] MORE_ENTRIES_RST = 32'd0;
    localparam logic [31:0] UNSUPPORTED_RST  = 32'd0;

    typedef struct packed {
        logic [6:0]  active_tags;
        logic [15:0] max_request_len;
        logic [7:0]  header_len;
        logic [31:0] more_entries_code;
        logic [31:0] unsupported_code;
    } cfg_t;

    typedef struct packed {
        action_t     action;
        logic [15:0] tag;
        logic [15:0] length;
        logic [15:0] capacity;
        logic [31:0] device_status;
    } item_t;

    typedef struct packed {
        logic [5:0] result_tag;
        outcome_t   outcome;
    } result_t;

endpackage

### rtl/inflight_request_tag_tracker.sv
// Request tag tracker. Each item on the s_ stream is an allocate, a response check
// or a release; each yields one result item on the m_ stream (action code 3 yields
// none). One item is accepted every cycle while results are taken; an accepted item
// passes the input register and then the result register before its result is
// presented on the m_ stream. The capacity table is read at the incoming tag as the
// item enters the input register, and from there the lowest-free-tag search and the
// checks run into the result register. A result that is not taken holds the item
// behind it in the input register, so at most two items are in flight before the
// input stalls. The capacity table is a TAG_COUNT-entry memory read at the incoming
// tag; it needs no clearing after reset, since only busy tags are ever checked
// against it. Configuration registers are written through cfg_we/cfg_index/cfg_data
// and must only be changed while no item is in flight.
module inflight_request_tag_tracker #(
    parameter int TAG_COUNT = 64
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // Configuration write port
    input  logic                               cfg_we,
    input  logic [iritt_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [iritt_pkg::CFG_DATA_W-1:0]   cfg_data,
    // Input items
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // action[1:0], tag[17:2], length[33:18], capacity[49:34], device_status[81:50]
    input  logic [iritt_pkg::IN_TDATA_W-1:0]   s_tdata,
    // Result items
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // result_tag[5:0], outcome[9:6]
    output logic [iritt_pkg::OUT_TDATA_W-1:0]  m_tdata
);

    import iritt_pkg::*;

    localparam int IW = (TAG_COUNT > 1) ? $clog2(TAG_COUNT) : 1;

    cfg_t          cfg_reg;
    item_t         item_reg;
    item_t         item_in;
    logic          item_valid_reg;
    result_t       res_reg;
    logic          res_valid_reg;
    result_t       res;
    logic          has_result;
    logic          out_free;
    logic          item_adv;
    logic          accept;
    logic [15:0]   cap_rd;
    logic          cap_we;
    logic [IW-1:0] cap_waddr;
    logic [15:0]   cap_wdata;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.active_tags       <= ACTIVE_TAGS_RST;
            cfg_reg.max_request_len   <= MAX_REQ_LEN_RST;
            cfg_reg.header_len        <= HEADER_LEN_RST;
            cfg_reg.more_entries_code <= MORE_ENTRIES_RST;
            cfg_reg.unsupported_code  <= UNSUPPORTED_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ACTIVE_TAGS:  cfg_reg.active_tags       <= cfg_data[6:0];
                CFG_MAX_REQ_LEN:  cfg_reg.max_request_len   <= cfg_data[15:0];
                CFG_HEADER_LEN:   cfg_reg.header_len        <= cfg_data[7:0];
                CFG_MORE_ENTRIES: cfg_reg.more_entries_code <= cfg_data;
                CFG_UNSUPPORTED:  cfg_reg.unsupported_code  <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Unpack the incoming item
    assign item_in.action        = action_t'(s_tdata[1:0]);
    assign item_in.tag           = s_tdata[17:2];
    assign item_in.length        = s_tdata[33:18];
    assign item_in.capacity      = s_tdata[49:34];
    assign item_in.device_status = s_tdata[81:50];

    // Handshake: the held item moves on when the result register can take it, or when it yields no result
    assign out_free = !res_valid_reg || m_tready;
    assign item_adv = item_valid_reg && (!has_result || out_free);
    assign s_tready = !item_valid_reg || item_adv;
    assign accept   = s_tvalid && s_tready;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            item_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_in;
        end
    end

    // Capacity table, read at the incoming tag
    iritt_cap_ram #(
        .DEPTH (TAG_COUNT)
    ) u_cap_ram (
        .clk   (clk),
        .we    (cap_we),
        .waddr (cap_waddr),
        .wdata (cap_wdata),
        .re    (accept),
        .raddr (item_in.tag[IW-1:0]),
        .rdata (cap_rd)
    );

    // Tag search, busy map and checks
    iritt_tag_ctrl #(
        .TAG_COUNT (TAG_COUNT)
    ) u_tag_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .upd_en     (item_adv),
        .item       (item_reg),
        .cfg        (cfg_reg),
        .cap_rd     (cap_rd),
        .has_result (has_result),
        .res        (res),
        .cap_we     (cap_we),
        .cap_waddr  (cap_waddr),
        .cap_wdata  (cap_wdata)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            res_valid_reg <= item_adv && has_result;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && item_adv && has_result)
        begin
            res_reg <= res;
        end
    end

    assign m_tvalid = res_valid_reg;
    assign m_tdata  = {6'd0, res_reg.outcome, res_reg.result_tag};

endmodule

### rtl/iritt_cap_ram.sv
module iritt_cap_ram #(
    parameter int DEPTH = 64
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [15:0]                                wdata,
    input  logic                                       re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [15:0]                                rdata
);

    logic [15:0] mem [DEPTH];
    logic [15:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read; a write to the same entry in the same cycle is passed through
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            if (we && (waddr == raddr))
            begin
                rdata_reg <= wdata;
            end
            else
            begin
                rdata_reg <= mem[raddr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/iritt_tag_ctrl.sv
module iritt_tag_ctrl #(
    parameter int TAG_COUNT = 64
) (
    input  logic                                               clk,
    input  logic                                               rst_n,
    input  logic                                               upd_en,
    input  iritt_pkg::item_t                                   item,
    input  iritt_pkg::cfg_t                                    cfg,
    input  logic [15:0]                                        cap_rd,
    output logic                                               has_result,
    output iritt_pkg::result_t                                 res,
    output logic                                               cap_we,
    output logic [((TAG_COUNT > 1) ? $clog2(TAG_COUNT) : 1)-1:0] cap_waddr,
    output logic [15:0]                                        cap_wdata
);

    import iritt_pkg::*;

    localparam int IW = (TAG_COUNT > 1) ? $clog2(TAG_COUNT) : 1;

    logic [TAG_COUNT-1:0] busy_map_reg;
    logic [TAG_COUNT-1:0] busy_map_next;
    logic [TAG_COUNT-1:0] free_vec;
    logic                 free_found;
    logic [IW-1:0]        free_idx;
    logic [IW-1:0]        tag_idx;
    logic                 tag_in_range;
    logic                 tag_busy;
    logic                 req_len_bad;
    logic                 resp_len_bad;
    logic                 alloc_ok;
    logic                 release_ok;

    // Tags that may be handed out: idle and below the active limit
    always_comb
    begin
        for (int i = 0; i < TAG_COUNT; i++)
        begin
            free_vec[i] = !busy_map_reg[i] && (32'(i) < 32'(cfg.active_tags));
        end
    end

    // Lowest free tag
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = TAG_COUNT - 1; i >= 0; i--)
        begin
            if (free_vec[i])
            begin
                free_found = 1'b1;
                free_idx   = IW'(i);
            end
        end
    end

    // Checks on the tag and lengths of the current item
    assign tag_idx      = item.tag[IW-1:0];
    assign tag_in_range = (item.tag < 16'(TAG_COUNT)) && (item.tag < {9'd0, cfg.active_tags});
    assign tag_busy     = tag_in_range ? busy_map_reg[tag_idx] : 1'b0;
    assign req_len_bad  = (item.length == 16'd0) || (item.length > cfg.max_request_len);
    assign resp_len_bad = (item.length < {8'd0, cfg.header_len}) || (item.length > cap_rd);

    assign alloc_ok   = (item.action == ACT_ALLOC) && free_found && !req_len_bad;
    assign release_ok = (item.action == ACT_RELEASE) && tag_in_range;

    // Outcome of the current item
    always_comb
    begin
        has_result     = 1'b1;
        res.result_tag = 6'(item.tag);
        res.outcome    = OUT_OK;
        case (item.action)
            ACT_ALLOC:
            begin
                if (!free_found)
                begin
                    res.result_tag = 6'd0;
                    res.outcome    = OUT_NO_FREE_TAG;
                end
                else
                begin
                    res.result_tag = 6'(free_idx);
                    res.outcome    = req_len_bad ? OUT_BAD_REQ_LEN : OUT_OK;
                end
            end
            ACT_RESPONSE:
            begin
                if (!tag_in_range)
                begin
                    res.outcome = OUT_TAG_RANGE;
                end
                else if (!tag_busy)
                begin
                    res.outcome = OUT_TAG_NOT_BUSY;
                end
                else if (resp_len_bad)
                begin
                    res.outcome = OUT_BAD_RESP_LEN;
                end
                else if ((item.device_status == 32'd0) ||
                         (item.device_status == cfg.more_entries_code))
                begin
                    res.outcome = OUT_OK;
                end
                else if (item.device_status == cfg.unsupported_code)
                begin
                    res.outcome = OUT_UNSUPPORTED;
                end
                else
                begin
                    res.outcome = OUT_FAILED;
                end
            end
            ACT_RELEASE:
            begin
                res.outcome = tag_in_range ? OUT_RELEASED : OUT_TAG_RANGE;
            end
            default:
            begin
                has_result = 1'b0;
            end
        endcase
    end

    // Capacity is recorded for every granted tag
    assign cap_we    = upd_en && alloc_ok;
    assign cap_waddr = free_idx;
    assign cap_wdata = item.capacity;

    // Busy map update
    always_comb
    begin
        busy_map_next = busy_map_reg;
        if (upd_en && alloc_ok)
        begin
            busy_map_next[free_idx] = 1'b1;
        end
        if (upd_en && release_ok)
        begin
            busy_map_next[tag_idx] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_map_reg <= '0;
        end
        else
        begin
            busy_map_reg <= busy_map_next;
        end
    end

    // A granted tag is busy from the next cycle on
    assert property (@(posedge clk) disable iff (!rst_n)
        (upd_en && alloc_ok) |=> busy_map_reg[$past(free_idx)])
        else $error("granted tag not marked busy");

    // A release within range leaves the tag idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (upd_en && release_ok) |=> !busy_map_reg[$past(tag_idx)])
        else $error("released tag still busy");

    // Capacity is only ever written for a tag that was idle
    assert property (@(posedge clk) disable iff (!rst_n)
        cap_we |-> !busy_map_reg[cap_waddr])
        else $error("capacity written for a busy tag");

endmodule

### bench/tb_inflight_request_tag_tracker.sv
module tb_inflight_request_tag_tracker;

    import iritt_pkg::*;

    localparam int TAG_COUNT     = 64;
    localparam int STALL_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES  = 10;
    localparam int LONG_HOLD     = 150;

    // The action code that the block ignores; it has no member in the package enum.
    localparam logic [1:0] ACT_UNKNOWN = 2'd3;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] tag;
        logic [15:0] length;
        logic [15:0] capacity;
        logic [31:0] status;
    } tag_item_t;

    typedef struct {
        bit          is_write;
        cfg_index_t  reg_idx;
        logic [31:0] reg_value;
        tag_item_t   item;
        bit          typed;
        result_t     result;
    } script_row_t;

    typedef struct {
        logic [6:0]  active;
        logic [15:0] max_len;
        logic [7:0]  hdr;
        logic [31:0] more;
        logic [31:0] unsup;
        int          items;
        int          tx_idle;
        int          rx_idle;
        bit          long_hold;
    } phase_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;

    // Shadow copy of the tracker state and its registers.
    logic [TAG_COUNT-1:0] tag_busy;
    logic [15:0]          tag_capacity [TAG_COUNT];
    logic [6:0]           cfg_active;
    logic [15:0]          cfg_max_len;
    logic [7:0]           cfg_hdr;
    logic [31:0]          cfg_more;
    logic [31:0]          cfg_unsup;

    result_t pending_results[$];
    int      mismatches;
    int      results_checked;
    int      items_sent;
    int      directed_items;
    int      settings_used;
    int      outcome_hits [16];
    int      tx_idle_pct;
    int      rx_idle_pct;
    bit      hold_request;

    inflight_request_tag_tracker #(
        .TAG_COUNT (TAG_COUNT)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // The active limit is the register value capped at the number of tags.
    function automatic int active_limit();
        return (cfg_active < TAG_COUNT) ? int'(cfg_active) : TAG_COUNT;
    endfunction

    // Works out the result of one item and updates the shadow state.
    function automatic bit predict_tag_result(input tag_item_t it, output result_t res);
        int limit;
        int t;
        limit = active_limit();
        res.result_tag = it.tag[5:0];
        res.outcome    = OUT_OK;
        if (it.action == ACT_ALLOC)
        begin
            t = 0;
            while (t < limit && tag_busy[t])
                t++;
            if (t >= limit)
            begin
                res.result_tag = 6'd0;
                res.outcome    = OUT_NO_FREE_TAG;
            end
            else
            begin
                res.result_tag = t[5:0];
                if (it.length == 16'd0 || it.length > cfg_max_len)
                    res.outcome = OUT_BAD_REQ_LEN;
                else
                begin
                    tag_busy[t]     = 1'b1;
                    tag_capacity[t] = it.capacity;
                end
            end
            return 1'b1;
        end
        if (it.action == ACT_RESPONSE)
        begin
            if (it.tag >= limit)
                res.outcome = OUT_TAG_RANGE;
            else if (!tag_busy[it.tag[5:0]])
                res.outcome = OUT_TAG_NOT_BUSY;
            else if (it.length < cfg_hdr || it.length > tag_capacity[it.tag[5:0]])
                res.outcome = OUT_BAD_RESP_LEN;
            else if (it.status == 32'd0 || it.status == cfg_more)
                res.outcome = OUT_OK;
            else if (it.status == cfg_unsup)
                res.outcome = OUT_UNSUPPORTED;
            else
                res.outcome = OUT_FAILED;
            return 1'b1;
        end
        if (it.action == ACT_RELEASE)
        begin
            if (it.tag >= limit)
                res.outcome = OUT_TAG_RANGE;
            else
            begin
                tag_busy[it.tag[5:0]] = 1'b0;
                res.outcome           = OUT_RELEASED;
            end
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Finds a busy tag below the active limit, starting from a random point.
    function automatic bit pick_busy_tag(output logic [15:0] tag);
        int start;
        int t;
        int limit;
        limit = active_limit();
        start = $urandom_range(TAG_COUNT - 1);
        tag   = '0;
        for (int i = 0; i < TAG_COUNT; i++)
        begin
            t = (start + i) % TAG_COUNT;
            if (t < limit && tag_busy[t])
            begin
                tag = t[15:0];
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Mostly well-formed traffic against live tags, with some noise.
    function automatic tag_item_t random_item();
        tag_item_t   it;
        int          r;
        int          s;
        logic [15:0] busy_tag;
        logic [15:0] cap;
        it.action   = ACT_ALLOC;
        it.tag      = 16'($urandom);
        it.length   = 16'($urandom);
        it.capacity = 16'($urandom);
        it.status   = $urandom;
        r = $urandom_range(99);
        s = $urandom_range(9);
        if (r < 30)
        begin
            if (s == 0)
                it.length = 16'd0;
            else if (s == 1)
                it.length = cfg_max_len + 16'd1;
            else if (s < 8)
                it.length = 16'($urandom_range(cfg_max_len, 1));
            if ($urandom_range(3) != 0)
                it.capacity = 16'($urandom_range(16'hFFFF, cfg_hdr));
        end
        else if (r < 65)
        begin
            it.action = ACT_RESPONSE;
            if (pick_busy_tag(busy_tag))
            begin
                it.tag = busy_tag;
                cap    = tag_capacity[busy_tag[5:0]];
                if (s < 6 && cap >= cfg_hdr)
                    it.length = 16'($urandom_range(cap, cfg_hdr));
                else if (s == 6)
                    it.length = {8'd0, cfg_hdr} - 16'd1;
                else if (s == 7)
                    it.length = cap + 16'd1;
            end
            else
                it.tag = 16'($urandom_range(active_limit() + 1));
            case ($urandom_range(3))
                0: it.status = 32'd0;
                1: it.status = cfg_more;
                2: it.status = cfg_unsup;
                default: ;
            endcase
        end
        else if (r < 85)
        begin
            it.action = ACT_RELEASE;
            if (!pick_busy_tag(it.tag))
                it.tag = 16'($urandom_range(TAG_COUNT - 1));
        end
        else
            it.action = 2'($urandom_range(3));
        return it;
    endfunction

    function automatic script_row_t item_row(logic [1:0] act, logic [15:0] tag,
                                             logic [15:0] len, logic [15:0] cap,
                                             logic [31:0] st);
        script_row_t row;
        row.is_write  = 1'b0;
        row.reg_idx   = CFG_ACTIVE_TAGS;
        row.reg_value = '0;
        row.item      = '{act, tag, len, cap, st};
        row.typed     = 1'b0;
        row.result    = '0;
        return row;
    endfunction

    function automatic script_row_t typed_row(logic [1:0] act, logic [15:0] tag,
                                              logic [15:0] len, logic [15:0] cap,
                                              logic [31:0] st, logic [5:0] want_tag,
                                              outcome_t want_outcome);
        script_row_t row;
        row                   = item_row(act, tag, len, cap, st);
        row.typed             = 1'b1;
        row.result.result_tag = want_tag;
        row.result.outcome    = want_outcome;
        return row;
    endfunction

    function automatic script_row_t reg_row(cfg_index_t idx, logic [31:0] value);
        script_row_t row;
        row           = item_row(ACT_ALLOC, '0, '0, '0, '0);
        row.is_write  = 1'b1;
        row.reg_idx   = idx;
        row.reg_value = value;
        return row;
    endfunction

    // Offers one item, waits for it to be taken and records its expected result.
    task automatic send_item(input tag_item_t it, input bit typed, input result_t typed_res);
        result_t res;
        bit      has_result;
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {6'd0, it.status, it.capacity, it.length, it.tag, it.action};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        has_result = predict_tag_result(it, res);
        if (has_result)
            pending_results.push_back(typed ? typed_res : res);
        items_sent++;
        @(negedge clk);
    endtask

    // Lets every pending result drain, then waits out the settle period for ignored items.
    task automatic settle();
        s_tvalid = 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [31:0] value);
        settle();
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            CFG_ACTIVE_TAGS:  cfg_active  = value[6:0];
            CFG_MAX_REQ_LEN:  cfg_max_len = value[15:0];
            CFG_HEADER_LEN:   cfg_hdr     = value[7:0];
            CFG_MORE_ENTRIES: cfg_more    = value;
            CFG_UNSUPPORTED:  cfg_unsup   = value;
            default: ;
        endcase
    endtask

    // Result receiver: random stalls, plus one long hold-off when asked.
    initial
    begin
        int hold_left;
        hold_left = 0;
        m_tready  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_left    = LONG_HOLD;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                m_tready = 1'b0;
                hold_left--;
            end
            else
                m_tready = ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Result checker: each accepted item is compared with the oldest expectation.
    initial
    begin
        result_t    want;
        logic [5:0] got_tag;
        outcome_t   got_outcome;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                got_tag     = m_tdata[5:0];
                got_outcome = outcome_t'(m_tdata[9:6]);
                outcome_hits[m_tdata[9:6]]++;
                if (pending_results.size() == 0)
                begin
                    $error("unexpected result: result_tag %0d, outcome %0d",
                           got_tag, got_outcome);
                    mismatches++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    results_checked++;
                    if (got_tag !== want.result_tag)
                    begin
                        $error("result_tag mismatch: expected %0d, actual %0d",
                               want.result_tag, got_tag);
                        mismatches++;
                    end
                    if (got_outcome !== want.outcome)
                    begin
                        $error("outcome mismatch: expected %0d, actual %0d",
                               want.outcome, got_outcome);
                        mismatches++;
                    end
                end
            end
        end
    end

    // Watchdog: ends the run if nothing moves on either side for too long.
    initial
    begin
        int stall_cycles;
        stall_cycles = 0;
        wait (rst_n);
        while (stall_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("Timeout: no item moved for %0d cycles", STALL_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Stimulus: directed script, then random phases under several settings.
    initial
    begin
        script_row_t script[$];
        phase_t      phase_plan[$];
        phase_t      ph;
        tag_item_t   it;
        result_t     unused;
        logic [31:0] shared_code;
        int          counted;

        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        unused      = '0;
        cfg_active  = ACTIVE_TAGS_RST;
        cfg_max_len = MAX_REQ_LEN_RST;
        cfg_hdr     = HEADER_LEN_RST;
        cfg_more    = MORE_ENTRIES_RST;
        cfg_unsup   = UNSUPPORTED_RST;
        tag_busy    = '0;

        // Reset values apply: 64 tags, request limit 4096, header 24, both codes zero.
        script.push_back(typed_row(ACT_RESPONSE, 16'd0, 16'd24, 16'd0, 32'd0,
                                   6'd0, OUT_TAG_NOT_BUSY));
        script.push_back(typed_row(ACT_RELEASE, 16'd63, 16'd0, 16'd0, 32'd0,
                                   6'd63, OUT_RELEASED));
        script.push_back(typed_row(ACT_RESPONSE, 16'd64, 16'd24, 16'd0, 32'd0,
                                   6'd0, OUT_TAG_RANGE));
        script.push_back(typed_row(ACT_RELEASE, 16'hFFFF, 16'd0, 16'd0, 32'd0,
                                   6'd63, OUT_TAG_RANGE));
        // Refused request lengths give the tag straight back.
        script.push_back(typed_row(ACT_ALLOC, 16'd0, 16'd0, 16'd100, 32'd0,
                                   6'd0, OUT_BAD_REQ_LEN));
        script.push_back(typed_row(ACT_ALLOC, 16'd0, 16'd4097, 16'd100, 32'd0,
                                   6'd0, OUT_BAD_REQ_LEN));
        script.push_back(typed_row(ACT_ALLOC, 16'hFFFF, 16'd4096, 16'hFFFF, 32'd0,
                                   6'd0, OUT_OK));
        script.push_back(typed_row(ACT_ALLOC, 16'd0, 16'd1, 16'd24, 32'd0,
                                   6'd1, OUT_OK));
        // Response length bounds and status classification.
        script.push_back(typed_row(ACT_RESPONSE, 16'd0, 16'd23, 16'd0, 32'd0,
                                   6'd0, OUT_BAD_RESP_LEN));
        script.push_back(typed_row(ACT_RESPONSE, 16'd0, 16'd24, 16'd0, 32'd0,
                                   6'd0, OUT_OK));
        script.push_back(typed_row(ACT_RESPONSE, 16'd1, 16'd25, 16'd0, 32'd0,
                                   6'd1, OUT_BAD_RESP_LEN));
        script.push_back(typed_row(ACT_RESPONSE, 16'd0, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF,
                                   6'd0, OUT_FAILED));
        script.push_back(item_row(ACT_UNKNOWN, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF));
        script.push_back(typed_row(ACT_RELEASE, 16'd0, 16'd0, 16'd0, 32'd0,
                                   6'd0, OUT_RELEASED));
        script.push_back(typed_row(ACT_RESPONSE, 16'd0, 16'd30, 16'd0, 32'd0,
                                   6'd0, OUT_TAG_NOT_BUSY));
        script.push_back(item_row(ACT_ALLOC, 16'd5, 16'd100, 16'd1000, 32'd0));
        // Distinct success and unsupported codes.
        script.push_back(reg_row(CFG_MORE_ENTRIES, 32'd5));
        script.push_back(reg_row(CFG_UNSUPPORTED, 32'd6));
        script.push_back(item_row(ACT_RESPONSE, 16'd1, 16'd24, 16'd0, 32'd5));
        script.push_back(item_row(ACT_RESPONSE, 16'd1, 16'd24, 16'd0, 32'd6));
        script.push_back(item_row(ACT_RESPONSE, 16'd1, 16'd24, 16'd0, 32'd0));
        // A lowered limit with both live tags busy leaves nothing to allocate.
        script.push_back(reg_row(CFG_ACTIVE_TAGS, 32'd2));
        script.push_back(typed_row(ACT_ALLOC, 16'd0, 16'd10, 16'd100, 32'd0,
                                   6'd0, OUT_NO_FREE_TAG));
        script.push_back(typed_row(ACT_RELEASE, 16'd2, 16'd0, 16'd0, 32'd0,
                                   6'd2, OUT_TAG_RANGE));
        // With no active tags every tag is out of range.
        script.push_back(reg_row(CFG_ACTIVE_TAGS, 32'd0));
        script.push_back(typed_row(ACT_ALLOC, 16'd0, 16'd10, 16'd100, 32'd0,
                                   6'd0, OUT_NO_FREE_TAG));
        script.push_back(typed_row(ACT_RESPONSE, 16'd0, 16'd24, 16'd0, 32'd0,
                                   6'd0, OUT_TAG_RANGE));
        script.push_back(reg_row(CFG_ACTIVE_TAGS, 32'd64));
        script.push_back(item_row(ACT_RESPONSE, 16'd1, 16'd24, 16'd0, 32'd7));
        script.push_back(item_row(ACT_RELEASE, 16'd1, 16'd0, 16'd0, 32'd0));

        // Random phases: register settings, item count, sender and receiver idling.
        phase_plan.push_back('{7'd64, 16'hFFFF, 8'd0, 32'hFFFF_FFFF, 32'd1,
                               240, 7, 85, 1'b0});
        phase_plan.push_back('{7'd4, 16'd1, 8'd255, $urandom, $urandom,
                               240, 7, 85, 1'b0});
        phase_plan.push_back('{7'd127, 16'd512, 8'd16, $urandom, $urandom,
                               240, 85, 7, 1'b0});
        phase_plan.push_back('{7'd1, 16'd4096, 8'd24, 32'd0, 32'd0,
                               300, 85, 7, 1'b0});
        phase_plan.push_back('{7'd16, 16'd2048, 8'd8, $urandom, $urandom,
                               260, 0, 0, 1'b1});
        shared_code = $urandom;
        phase_plan.push_back('{7'd64, 16'd300, 8'd200, shared_code, shared_code,
                               240, 0, 0, 1'b0});
        phase_plan.push_back('{7'd0, 16'd100, 8'd0, $urandom, $urandom,
                               40, 0, 0, 1'b0});

        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        foreach (script[i])
        begin
            if (script[i].is_write)
                write_reg(script[i].reg_idx, script[i].reg_value);
            else
            begin
                send_item(script[i].item, script[i].typed, script[i].result);
                directed_items++;
            end
        end

        foreach (phase_plan[p])
        begin
            ph = phase_plan[p];
            write_reg(CFG_ACTIVE_TAGS, {25'd0, ph.active});
            write_reg(CFG_MAX_REQ_LEN, {16'd0, ph.max_len});
            write_reg(CFG_HEADER_LEN, {24'd0, ph.hdr});
            write_reg(CFG_MORE_ENTRIES, ph.more);
            write_reg(CFG_UNSUPPORTED, ph.unsup);
            settings_used++;
            tx_idle_pct = ph.tx_idle;
            rx_idle_pct = ph.rx_idle;
            if (ph.long_hold)
                hold_request = 1'b1;
            counted = 0;
            while (counted < ph.items)
            begin
                it = random_item();
                send_item(it, 1'b0, unused);
                if (it.action != ACT_UNKNOWN)
                    counted++;
            end
        end

        // Drain, then watch a little longer for stray results.
        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d items (%0d directed) across %0d register settings; %0d results checked.",
                 items_sent, directed_items, settings_used, results_checked);
        $display("Outcomes ok/nofree/badreq/range/notbusy/badresp/unsup/failed/released:",
                 " %0d %0d %0d %0d %0d %0d %0d %0d %0d",
                 outcome_hits[0], outcome_hits[1], outcome_hits[2], outcome_hits[3],
                 outcome_hits[4], outcome_hits[5], outcome_hits[6], outcome_hits[7],
                 outcome_hits[8]);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
